/* rtl/bva_pkg.sv */
// ----------------------------------------------------------------------------
// bva_pkg
// Widths, operation codes and stage payload types shared by the bit-vector
// ALU, its execute unit and its channel interfaces.
// ----------------------------------------------------------------------------
package bva_pkg;

   // Datapath width. Operands are reduced to this many bits before use.
   localparam int WIDTH  = 32;

   // Fixed field widths of the channels.
   localparam int OP_W   = 5;
   localparam int OPND_W = 32;
   localparam int FLD_W  = 6;
   localparam int RES_W  = 32;

   // Shift amount bits for an in-range shift, and the width in which field
   // bounds are compared against WIDTH.
   localparam int SH_W   = (WIDTH > 1) ? $clog2(WIDTH) : 1;
   localparam int CNT_W  = $clog2(WIDTH + 1);
   localparam int FCNT_W = (CNT_W > FLD_W) ? CNT_W : FLD_W;

   typedef logic [WIDTH-1:0] word_type;

   localparam word_type SIGN_BIT = word_type'(1) << (WIDTH - 1);

   typedef enum logic [OP_W-1:0] {
      OP_ADD     = 5'd0,
      OP_SUB     = 5'd1,
      OP_SHL     = 5'd2,
      OP_SHR     = 5'd3,
      OP_SRA     = 5'd4,
      OP_MUL     = 5'd5,
      OP_AND     = 5'd6,
      OP_OR      = 5'd7,
      OP_XOR     = 5'd8,
      OP_NOT     = 5'd9,
      OP_EQ      = 5'd10,
      OP_NE      = 5'd11,
      OP_ULT     = 5'd12,
      OP_UGT     = 5'd13,
      OP_ULE     = 5'd14,
      OP_UGE     = 5'd15,
      OP_SLT     = 5'd16,
      OP_SGT     = 5'd17,
      OP_EXTRACT = 5'd18
   } op_type;

   // Decoded operands after the input stage.
   typedef struct packed {
      op_type                op;
      word_type              a;
      word_type              b;
      logic                  big_shift;
      logic [SH_W-1:0]       shamt;
      logic [FLD_W-1:0]      fld_lo;
      word_type              fld_mask;
   } s1_type;

   // Execute stage results: the product and everything else, kept apart.
   typedef struct packed {
      op_type                op;
      word_type              prod;
      word_type              value;
   } s2_type;

endpackage

/* rtl/bva_req_if.sv */
// ----------------------------------------------------------------------------
// bva_req_if
// Request channel of the bit-vector ALU: valid/ready plus operation fields.
// ----------------------------------------------------------------------------
interface bva_req_if;
   import bva_pkg::*;

   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    operation;
   logic [OPND_W-1:0]  operand_a;
   logic [OPND_W-1:0]  operand_b;
   logic [FLD_W-1:0]   field_start;
   logic [FLD_W-1:0]   field_end;

   modport source (
      output valid, operation, operand_a, operand_b, field_start, field_end,
      input  ready
   );

   modport sink (
      input  valid, operation, operand_a, operand_b, field_start, field_end,
      output ready
   );

endinterface

/* rtl/bva_rsp_if.sv */
// ----------------------------------------------------------------------------
// bva_rsp_if
// Response channel of the bit-vector ALU: valid/ready plus the result word.
// ----------------------------------------------------------------------------
interface bva_rsp_if;
   import bva_pkg::*;

   logic              valid;
   logic              ready;
   logic [RES_W-1:0]  result_value;

   modport source (
      output valid, result_value,
      input  ready
   );

   modport sink (
      input  valid, result_value,
      output ready
   );

endinterface

/* rtl/bva_exec.sv */
// ----------------------------------------------------------------------------
// bva_exec
// Execute stage logic: product, adder, compares, shifts, logic and field
// extraction on decoded operands. The multiply result is kept separate so
// that the final select happens one stage later.
// ----------------------------------------------------------------------------
module bva_exec (
   input  bva_pkg::s1_type stage_in,
   output bva_pkg::s2_type stage_out
);
   import bva_pkg::*;

   word_type         a;
   word_type         b;
   logic [WIDTH:0]   udiff;
   logic [WIDTH:0]   sdiff;
   logic             eq;
   logic             ult;
   logic             slt;
   word_type         sra_val;

   assign a = stage_in.a;
   assign b = stage_in.b;

   // Borrow out of the subtraction gives less-than; flipping the sign bits
   // turns the signed compare into an unsigned one.
   assign udiff   = {1'b0, a} - {1'b0, b};
   assign sdiff   = {1'b0, a ^ SIGN_BIT} - {1'b0, b ^ SIGN_BIT};
   assign eq      = (a == b);
   assign ult     = udiff[WIDTH];
   assign slt     = sdiff[WIDTH];
   assign sra_val = word_type'($signed(a) >>> stage_in.shamt);

   always_comb begin
      stage_out.op   = stage_in.op;
      stage_out.prod = a * b;
      case (stage_in.op)
         OP_ADD:     stage_out.value = a + b;
         OP_SUB:     stage_out.value = a - b;
         OP_SHL:     stage_out.value = stage_in.big_shift ? '0 : (a << stage_in.shamt);
         OP_SHR:     stage_out.value = stage_in.big_shift ? '0 : (a >> stage_in.shamt);
         OP_SRA:     stage_out.value = stage_in.big_shift ? {WIDTH{a[WIDTH-1]}} : sra_val;
         OP_AND:     stage_out.value = a & b;
         OP_OR:      stage_out.value = a | b;
         OP_XOR:     stage_out.value = a ^ b;
         OP_NOT:     stage_out.value = ~a;
         OP_EQ:      stage_out.value = word_type'(eq);
         OP_NE:      stage_out.value = word_type'(!eq);
         OP_ULT:     stage_out.value = word_type'(ult);
         OP_UGT:     stage_out.value = word_type'(!ult && !eq);
         OP_ULE:     stage_out.value = word_type'(ult || eq);
         OP_UGE:     stage_out.value = word_type'(!ult);
         OP_SLT:     stage_out.value = word_type'(slt);
         OP_SGT:     stage_out.value = word_type'(!slt && !eq);
         OP_EXTRACT: stage_out.value = (a >> stage_in.fld_lo) & stage_in.fld_mask;
         default:    stage_out.value = '0;
      endcase
   end

endmodule

/* rtl/bit_vector_alu.sv */
// ----------------------------------------------------------------------------
// bit_vector_alu
// Three-stage pipelined integer ALU: add, subtract, shifts, multiply (low
// half), bitwise logic, compares and bit-field extract.
//
//   Channel   Direction  Handshake      Payload
//   req_chan  in         valid/ready    operation, operand_a, operand_b,
//                                       field_start, field_end
//   rsp_chan  out        valid/ready    result_value
//
// Every operation passes three register stages: decode, execute (multiplier
// and adder), final select into the output register. A response is valid once
// its item reaches the output register; a stall can hold the item in any stage.
// One request is accepted per cycle when the response side keeps up.
// A stall holds each full stage; an empty stage still fills, so bubbles close.
// Reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
module bit_vector_alu (
   input  logic        clock,
   input  logic        reset,
   bva_req_if.sink     req_chan,
   bva_rsp_if.source   rsp_chan
);
   import bva_pkg::*;

   logic              s1_valid_ff;
   s1_type            s1_ff;
   s1_type            s1_in;
   logic              s2_valid_ff;
   s2_type            s2_ff;
   s2_type            s2_in;
   logic              out_valid_ff;
   logic [RES_W-1:0]  out_value_ff;
   logic [RES_W-1:0]  out_value_in;

   logic              s1_en;
   logic              s2_en;
   logic              out_en;

   word_type              opnd_b;
   logic [FCNT_W-1:0]     fs_w;
   logic [FCNT_W-1:0]     fe_w;
   logic [FCNT_W-1:0]     fe_clamp;
   logic [FCNT_W-1:0]     fld_len;

   // A stage loads when it is empty or its contents move on this cycle.
   assign out_en = !out_valid_ff || rsp_chan.ready;
   assign s2_en  = !s2_valid_ff || out_en;
   assign s1_en  = !s1_valid_ff || s2_en;

   assign req_chan.ready        = s1_en;
   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.result_value = out_value_ff;

   // Decode: reduce operands, flag out-of-range shifts, build the field mask.
   assign opnd_b   = word_type'(req_chan.operand_b);
   assign fs_w     = FCNT_W'(req_chan.field_start);
   assign fe_w     = FCNT_W'(req_chan.field_end);
   assign fe_clamp = (fe_w > FCNT_W'(WIDTH)) ? FCNT_W'(WIDTH) : fe_w;
   assign fld_len  = fe_clamp - fs_w;

   always_comb begin
      s1_in.op        = op_type'(req_chan.operation);
      s1_in.a         = word_type'(req_chan.operand_a);
      s1_in.b         = opnd_b;
      s1_in.big_shift = (OPND_W'(opnd_b) >= OPND_W'(WIDTH));
      s1_in.shamt     = opnd_b[SH_W-1:0];
      s1_in.fld_lo    = req_chan.field_start;
      if (fs_w < fe_clamp) begin
         if (fld_len >= FCNT_W'(WIDTH)) begin
            s1_in.fld_mask = '1;
         end else begin
            s1_in.fld_mask = ~(word_type'('1) << fld_len);
         end
      end else begin
         s1_in.fld_mask = '0;
      end
   end

   bva_exec u_exec (
      .stage_in  (s1_ff),
      .stage_out (s2_in)
   );

   assign out_value_in = RES_W'((s2_ff.op == OP_MUL) ? s2_ff.prod : s2_ff.value);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_en) begin
            s1_valid_ff <= req_chan.valid;
         end
         if (s2_en) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (out_en) begin
            out_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_ff <= s1_in;
      end
      if (s2_en) begin
         s2_ff <= s2_in;
      end
      if (out_en) begin
         out_value_ff <= out_value_in;
      end
   end

   // A request transfer always lands in the decode stage.
   a_req_fills_s1 : assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> s1_valid_ff)
      else $error("request transfer did not reach the decode stage");

   // An executed item moves into the output register when it advances.
   a_s2_to_out : assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && out_en |=> rsp_chan.valid)
      else $error("executed item lost on the way to the output register");

   // With every stage full and the response stalled, no request is taken.
   a_full_stall : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_chan.ready && s2_valid_ff && s1_valid_ff |-> !req_chan.ready)
      else $error("request accepted while the pipeline is full and stalled");

   // Compare operations produce only zero or one.
   a_cmp_bool : assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && (s2_ff.op == OP_EQ || s2_ff.op == OP_NE || s2_ff.op == OP_ULT ||
                      s2_ff.op == OP_UGT || s2_ff.op == OP_ULE || s2_ff.op == OP_UGE ||
                      s2_ff.op == OP_SLT || s2_ff.op == OP_SGT)
      |-> (s2_ff.value >> 1) == '0)
      else $error("compare result wider than one bit");

endmodule
